>>> rtl/spl_pkg.sv
// ----------------------------------------------------------------------------
// spl_pkg: shared types for the sorted priority list
// Request and response payloads, command and status codes, and the
// structs that pass between the list cells and the top level.
// ----------------------------------------------------------------------------
package spl_pkg;

	// Command codes
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} spl_cmd_t;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BEYOND    = 2'd3
	} spl_status_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  entry_id;
		logic [15:0] entry_key;
		logic [3:0]  position;
	} spl_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  read_id;
		logic [15:0] read_key;
		logic [4:0]  count;
		logic [19:0] key_sum;
	} spl_rsp_t;

	// Broadcast to every cell for one request
	typedef struct packed {
		logic        ins;
		logic        rem;
		logic [15:0] key;
		logic [7:0]  id;
	} spl_ctl_t;

	// What a cell shows its neighbors and the top level
	typedef struct packed {
		logic        lt;     // occupied and key below the new key
		logic        found;  // a matching id at this cell or to its left
		logic        first;  // this cell holds the first matching id
		logic [15:0] key;
		logic [7:0]  id;
	} spl_link_t;

endpackage

>>> rtl/spl_cell.sv
// ----------------------------------------------------------------------------
// spl_cell: one slot of the sorted list
// Holds one key and id. On insert it keeps its entry, takes the new entry,
// or takes its left neighbor's; on remove it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spl_cell (
	input  logic              clk,
	input  spl_pkg::spl_ctl_t ctl,
	input  logic              occ,
	input  spl_pkg::spl_link_t prev,
	input  spl_pkg::spl_link_t next,
	output spl_pkg::spl_link_t link
);
	import spl_pkg::*;

	logic [15:0] key_q;
	logic [7:0]  id_q;
	logic        lt;
	logic        match;

	// Local compares and the found chain
	always_comb begin
		lt         = occ && (key_q < ctl.key);
		match      = occ && (id_q == ctl.id);
		link.lt    = lt;
		link.found = prev.found | match;
		link.first = match & ~prev.found;
		link.key   = key_q;
		link.id    = id_q;
	end

	// Slot contents: shift right on insert, shift left on remove
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt) begin
			if (prev.lt) begin
				key_q <= ctl.key;
				id_q  <= ctl.id;
			end else begin
				key_q <= prev.key;
				id_q  <= prev.id;
			end
		end else if (ctl.rem && link.found) begin
			key_q <= next.key;
			id_q  <= next.id;
		end
	end

endmodule

>>> rtl/sorted_priority_list.sv
// Sorted priority list: a row of DEPTH compare-and-shift cells.
// The response is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while the response side is ready; each
// insert, remove or read completes in the acceptance cycle across all cells.
// A response still waiting in the output register holds off the next request.
// Reset: count and key sum clear at once; slot contents are not reset.
// ----------------------------------------------------------------------------
// sorted_priority_list: top level
// Ascending-key store with insert, remove by id and read by position,
// reporting entry count and running key sum with every response.
// ----------------------------------------------------------------------------
module sorted_priority_list #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  spl_pkg::spl_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output spl_pkg::spl_rsp_t rsp
);
	import spl_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 4) ? CW : 4;

	logic [CW-1:0] count_q;
	logic [20:0]   sum_q;
	logic          rsp_valid_q;
	spl_rsp_t      rsp_q;

	logic          accept;
	logic          full;
	logic          pos_ok;
	logic [PW-1:0] pos_w;
	spl_ctl_t      ctl;
	spl_link_t     links [DEPTH];
	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] sel;
	logic [15:0]   rem_key;
	logic [15:0]   rd_key;
	logic [7:0]    rd_id;
	logic          found;
	logic [CW-1:0] count_d;
	logic [20:0]   sum_d;
	spl_rsp_t      rsp_d;

	assign accept    = req_valid & req_ready;
	assign req_ready = ~rsp_valid_q | rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full   = (count_q == CW'(DEPTH));
	assign pos_w  = PW'(req.position);
	assign pos_ok = (pos_w < PW'(count_q));

	// Broadcast control, gated by acceptance
	always_comb begin
		ctl.ins = accept && (req.command == CMD_INSERT) && !full;
		ctl.rem = accept && (req.command == CMD_REMOVE);
		ctl.key = req.entry_key;
		ctl.id  = req.entry_id;
	end

	// Cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spl_link_t prev_l;
		spl_link_t next_l;

		assign occ[i] = (CW'(i) < count_q);
		assign sel[i] = (pos_w == PW'(i));

		if (i == 0) begin : g_first
			assign prev_l = '{lt: 1'b1, found: 1'b0, first: 1'b0, key: '0, id: '0};
		end else begin : g_mid
			assign prev_l = links[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_l = links[i];
		end else begin : g_inner
			assign next_l = links[i+1];
		end

		spl_cell u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.occ  (occ[i]),
			.prev (prev_l),
			.next (next_l),
			.link (links[i])
		);
	end

	// Gather the removed key and the read entry (one-hot selects)
	always_comb begin
		rem_key = '0;
		rd_key  = '0;
		rd_id   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rem_key = rem_key | (links[i].key & {16{links[i].first}});
			rd_key  = rd_key | (links[i].key & {16{sel[i]}});
			rd_id   = rd_id | (links[i].id & {8{sel[i]}});
		end
		found = links[DEPTH-1].found;
	end

	// Next count, sum and response
	always_comb begin
		count_d        = count_q;
		sum_d          = sum_q;
		rsp_d.status   = ST_OK;
		rsp_d.read_id  = '0;
		rsp_d.read_key = '0;
		case (req.command)
			CMD_INSERT: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
					sum_d   = sum_q + 21'(req.entry_key);
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					count_d = count_q - CW'(1);
					sum_d   = sum_q - 21'(rem_key);
				end else begin
					rsp_d.status = ST_NOT_FOUND;
				end
			end
			CMD_READ: begin
				if (pos_ok) begin
					rsp_d.read_id  = rd_id;
					rsp_d.read_key = rd_key;
				end else begin
					rsp_d.status = ST_BEYOND;
				end
			end
			default: begin
			end
		endcase
		rsp_d.count   = 5'(count_d);
		rsp_d.key_sum = sum_d[19:0];
	end

	// State and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				sum_q       <= sum_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sorted priority list regression
// Drives insert, remove, read and unused commands through the request channel.
// A scoreboard keeps its own sorted list and predicts every response, and
// each response is checked field by field. Both channels idle at random, and
// one phase stalls the response side long enough to back up the request side.
// ----------------------------------------------------------------------------
module testbench;
	import spl_pkg::*;

	localparam int LIST_DEPTH  = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;
	localparam int LONG_HOLD   = 300;

	// Idle patterns for either channel
	localparam int PACE_STEADY = 0;
	localparam int PACE_RANDOM = 1;
	localparam int PACE_BURSTY = 2;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	spl_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	spl_rsp_t rsp;

	// Scoreboard copy of the list
	logic [15:0] list_keys [LIST_DEPTH];
	logic [7:0]  list_ids  [LIST_DEPTH];
	int          list_count;
	logic [20:0] list_sum;

	spl_rsp_t predicted_rsp [$];
	int       mismatches  = 0;
	int       idle_cycles = 0;
	int       send_pace   = PACE_STEADY;
	int       take_pace   = PACE_STEADY;
	int       hold_off    = 0;

	sorted_priority_list #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_gap(input int pace);
		case (pace)
			PACE_STEADY: return 0;
			PACE_RANDOM: return $urandom_range(0, 14);
			default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		endcase
	endfunction

	// Apply one request to the scoreboard list and return its response
	function automatic spl_rsp_t apply_to_list(input spl_req_t item);
		spl_rsp_t outcome;
		int       at;
		outcome = '0;
		at = 0;
		case (spl_cmd_t'(item.command))
			CMD_INSERT: begin
				if (list_count >= LIST_DEPTH) begin
					outcome.status = ST_FULL;
				end else begin
					// new entry goes ahead of the first key not below it
					while (at < list_count && list_keys[at] < item.entry_key)
						at++;
					for (int i = list_count; i > at; i--) begin
						list_keys[i] = list_keys[i - 1];
						list_ids[i]  = list_ids[i - 1];
					end
					list_keys[at] = item.entry_key;
					list_ids[at]  = item.entry_id;
					list_count++;
					list_sum = list_sum + item.entry_key;
				end
			end
			CMD_REMOVE: begin
				while (at < list_count && list_ids[at] != item.entry_id)
					at++;
				if (at >= list_count) begin
					outcome.status = ST_NOT_FOUND;
				end else begin
					list_sum = list_sum - list_keys[at];
					for (int i = at; i + 1 < list_count; i++) begin
						list_keys[i] = list_keys[i + 1];
						list_ids[i]  = list_ids[i + 1];
					end
					list_count--;
				end
			end
			CMD_READ: begin
				if (item.position < list_count) begin
					outcome.read_id  = list_ids[item.position];
					outcome.read_key = list_keys[item.position];
				end else begin
					outcome.status = ST_BEYOND;
				end
			end
			default: ;
		endcase
		outcome.count   = list_count[4:0];
		outcome.key_sum = list_sum[19:0];
		return outcome;
	endfunction

	function automatic spl_req_t make_request(input spl_cmd_t cmd, input logic [7:0] id,
			input logic [15:0] key, input logic [3:0] pos);
		spl_req_t item;
		item.command   = cmd;
		item.entry_id  = id;
		item.entry_key = key;
		item.position  = pos;
		return item;
	endfunction

	// Random request; insert_pct steers the fill level, id_span narrows ids
	function automatic spl_req_t make_random_request(input int insert_pct, input int id_span);
		spl_req_t item;
		int       roll;
		roll = $urandom_range(0, 99);
		if (roll < insert_pct)
			item.command = CMD_INSERT;
		else if (roll < insert_pct + (97 - insert_pct) / 2)
			item.command = CMD_REMOVE;
		else if (roll < 97)
			item.command = CMD_READ;
		else
			item.command = CMD_NOP;

		item.entry_id = 8'($urandom_range(0, id_span - 1));
		if (item.command == CMD_REMOVE && list_count > 0 && $urandom_range(0, 3) != 0)
			item.entry_id = list_ids[$urandom_range(0, list_count - 1)];

		case ($urandom_range(0, 7))
			0:       item.entry_key = 16'h0000;
			1:       item.entry_key = 16'hFFFF;
			2, 3:    item.entry_key = 16'($urandom_range(0, 15));
			default: item.entry_key = 16'($urandom_range(0, 65535));
		endcase

		if (list_count > 0 && $urandom_range(0, 1) == 0)
			item.position = 4'($urandom_range(0, list_count - 1));
		else
			item.position = 4'($urandom_range(0, 15));
		return item;
	endfunction

	// Offer one request, starting and ending on a falling edge
	task automatic send_request(input spl_req_t item);
		int gap;
		gap = draw_gap(send_pace);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       = item;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		predicted_rsp.push_back(apply_to_list(item));
		@(negedge clk);
	endtask

	task automatic note_failure(input string what, input spl_rsp_t want, input spl_rsp_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display({"%0t %s: expected st=%0d id=%h key=%h cnt=%0d sum=%h, ",
				"got st=%0d id=%h key=%h cnt=%0d sum=%h"},
				$time, what, want.status, want.read_id, want.read_key, want.count,
				want.key_sum, got.status, got.read_id, got.read_key, got.count,
				got.key_sum);
	endtask

	// Response side: random ready gaps, plus a long hold when one is requested
	initial begin : response_taker
		int gap;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = (hold_off > 0) ? hold_off : draw_gap(take_pace);
			hold_off = 0;
			if (gap > 0) begin
				rsp_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready = 1'b1;
			do
				@(posedge clk);
			while (!rsp_valid);
		end
	end

	// Response checker
	always @(posedge clk) begin
		spl_rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (predicted_rsp.size() == 0) begin
				note_failure("unexpected response", '0, rsp);
			end else begin
				want = predicted_rsp.pop_front();
				if (rsp.status !== want.status || rsp.read_id !== want.read_id
						|| rsp.read_key !== want.read_key || rsp.count !== want.count
						|| rsp.key_sum !== want.key_sum)
					note_failure("response mismatch", want, rsp);
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Empty-store cases, extremes, equal keys, duplicate ids and a full store
	task automatic test_directed_cases();
		send_request(make_request(CMD_READ, 8'h00, 16'h0000, 4'd0));
		send_request(make_request(CMD_REMOVE, 8'h5A, 16'h0000, 4'd0));
		send_request(make_request(CMD_NOP, 8'hFF, 16'hFFFF, 4'hF));
		send_request(make_request(CMD_INSERT, 8'hFF, 16'hFFFF, 4'd0));
		send_request(make_request(CMD_INSERT, 8'h00, 16'h0000, 4'hF));
		// equal key lands ahead of the older entry
		send_request(make_request(CMD_INSERT, 8'h07, 16'hFFFF, 4'd0));
		send_request(make_request(CMD_READ, 8'h00, 16'h0000, 4'd1));
		send_request(make_request(CMD_READ, 8'h00, 16'h0000, 4'd2));
		send_request(make_request(CMD_READ, 8'hFF, 16'hFFFF, 4'd3));
		send_request(make_request(CMD_REMOVE, 8'h09, 16'h0000, 4'd0));
		send_request(make_request(CMD_REMOVE, 8'hFF, 16'h0000, 4'd0));
		// fill up, with repeated ids and keys
		for (int i = 0; i < LIST_DEPTH - 2; i++)
			send_request(make_request(CMD_INSERT, (i % 3 == 0) ? 8'h07 : 8'(16 + i),
				16'(4096 * (i % 5)), 4'd0));
		send_request(make_request(CMD_INSERT, 8'hAA, 16'h0001, 4'd0));
		send_request(make_request(CMD_READ, 8'h00, 16'h0000, 4'hF));
		send_request(make_request(CMD_REMOVE, 8'h07, 16'h0000, 4'd0));
	endtask

	// Phases that fill, churn and drain the list under different idle patterns
	task automatic test_random_traffic();
		int fill_pct [4] = '{85, 50, 15, 50};
		for (int phase = 0; phase < 20; phase++) begin
			send_pace = phase % 3;
			take_pace = (phase / 3) % 3;
			repeat (100)
				send_request(make_random_request(fill_pct[phase % 4],
					(phase % 3 == 0) ? 8 : 256));
		end
	endtask

	// Response side holds off while requests keep coming
	task automatic test_backpressure();
		send_pace = PACE_STEADY;
		take_pace = PACE_STEADY;
		hold_off  = LONG_HOLD;
		repeat (40)
			send_request(make_random_request(50, 256));
		take_pace = PACE_RANDOM;
		repeat (20)
			send_request(make_random_request(50, 256));
	endtask

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		list_count = 0;
		list_sum   = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			list_keys[i] = '0;
			list_ids[i]  = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_traffic();
		test_backpressure();
		req_valid = 1'b0;

		wait (predicted_rsp.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && predicted_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
